@@ rtl/core/modexp_pkg.sv @@
// Package with shared constants and the modular reduction step for the modexp block.
`default_nettype none

package modexp_pkg;

  // Field widths.
  localparam int BASE_W = 30;
  localparam int EXP_W  = 32;

  // Number of exponent bits that are scanned.
  localparam int EXP_BITS = 32;

  // Width of a partial sum inside the bit-serial multiplier (holds up to 3P).
  localparam int SUM_W = BASE_W + 2;

  // The prime modulus and its double.
  localparam logic [SUM_W-1:0] PRIME_MOD   = SUM_W'(1000000007);
  localparam logic [SUM_W-1:0] PRIME_MOD_2 = SUM_W'(2000000014);

  // Exponent bits at or above EXP_BITS are ignored.
  localparam logic [EXP_W-1:0] EXP_MASK =
    (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} : EXP_W'((64'd1 << EXP_BITS) - 64'd1);

  // Bit index width for one pass over a residue.
  localparam int IDX_W = $clog2(BASE_W);

  // Bring a value below 3P back below P.
  function automatic logic [BASE_W-1:0] mod_reduce(input logic [SUM_W-1:0] t);
    logic [SUM_W-1:0] r;
    begin
      if (t >= PRIME_MOD_2) begin
        r = t - PRIME_MOD_2;
      end else if (t >= PRIME_MOD) begin
        r = t - PRIME_MOD;
      end else begin
        r = t;
      end
      return r[BASE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/modular_exponentiation_prime_modulus.sv @@
// Top level: base to the exponent modulo 1000000007 by bit-serial square-and-multiply.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   input   | in        | in_valid / in_ready  | base_value[29:0], exponent[31:0]
//   output  | out       | out_valid / out_ready| power_result[29:0]
//
// One item is worked at a time. Each exponent bit is one pass of two bit-serial
// modular multipliers (result times square, square times square) that consume one bit
// of the running square per cycle. An item runs one pass per exponent bit up to its
// highest set bit; exponent zero goes straight from idle to the result.
// The result is held in out_valid/power_result until taken; in_ready is low meanwhile.
// Reset (rst, synchronous) returns the block to idle and drops any item in flight.
`default_nettype none

module modular_exponentiation_prime_modulus
  import modexp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BASE_W-1:0] base_value,
  input  wire logic [EXP_W-1:0]  exponent,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BASE_W-1:0]      power_result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DONE
  } state_t;

  state_t             state;
  logic [BASE_W-1:0]  acc;        // running result
  logic [BASE_W-1:0]  sq;         // running square
  logic [EXP_W-1:0]   exp_reg;    // remaining exponent bits
  logic [BASE_W-1:0]  sq_shift;   // multiplier bits, MSB first
  logic [BASE_W-1:0]  acc_prod;   // partial product acc * sq
  logic [BASE_W-1:0]  sq_prod;    // partial product sq * sq
  logic [IDX_W-1:0]   bit_idx;

  logic               mul_bit;
  logic [SUM_W-1:0]   acc_sum;
  logic [SUM_W-1:0]   sq_sum;
  logic [BASE_W-1:0]  acc_prod_next;
  logic [BASE_W-1:0]  sq_prod_next;
  logic [SUM_W-1:0]   base_ext;
  logic [BASE_W-1:0]  base_red;
  logic [EXP_W-1:0]   exp_load;
  logic [EXP_W-1:0]   exp_shifted;

  assign in_ready     = (state == ST_IDLE);
  assign out_valid    = (state == ST_DONE);
  assign power_result = acc;

  // Input conditioning: base below 2^30 < 2P needs at most one subtraction.
  assign base_ext = SUM_W'(base_value);
  assign base_red = mod_reduce(base_ext);
  assign exp_load = exponent & EXP_MASK;

  // One step of both interleaved multipliers: sum = 2*partial + bit*operand.
  assign mul_bit       = sq_shift[BASE_W-1];
  assign acc_sum       = {1'b0, acc_prod, 1'b0} + (mul_bit ? SUM_W'(acc) : '0);
  assign sq_sum        = {1'b0, sq_prod, 1'b0} + (mul_bit ? SUM_W'(sq) : '0);
  assign acc_prod_next = mod_reduce(acc_sum);
  assign sq_prod_next  = mod_reduce(sq_sum);
  assign exp_shifted   = exp_reg >> 1;

  // Sequencer: state, operands and the bit-serial multipliers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            acc      <= BASE_W'(1);
            sq       <= base_red;
            exp_reg  <= exp_load;
            sq_shift <= base_red;
            acc_prod <= '0;
            sq_prod  <= '0;
            bit_idx  <= IDX_W'(BASE_W - 1);
            state    <= (exp_load == '0) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          if (bit_idx == '0) begin
            // Last multiplier bit: commit the square, and the product when the bit is set.
            sq <= sq_prod_next;
            if (exp_reg[0]) begin
              acc <= acc_prod_next;
            end
            exp_reg  <= exp_shifted;
            sq_shift <= sq_prod_next;
            acc_prod <= '0;
            sq_prod  <= '0;
            bit_idx  <= IDX_W'(BASE_W - 1);
            if (exp_shifted == '0) begin
              state <= ST_DONE;
            end
          end else begin
            acc_prod <= acc_prod_next;
            sq_prod  <= sq_prod_next;
            sq_shift <= sq_shift << 1;
            bit_idx  <= bit_idx - IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/modexp_checker.sv @@
// Port-level checker for the modexp block and its bind to the top level.
`default_nettype none

module modexp_checker
  import modexp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BASE_W-1:0] power_result
);

  // A waiting result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(power_result))
    else $error("result beat changed while stalled");

  // The block never takes an input while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // An accepted input closes the input side until its result is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input accepted while one is in work");

  // Once the result beat is taken, the block is free again.
  a_free_after_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block not idle after result beat");

  // Every result is below the modulus.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({2'b00, power_result} < PRIME_MOD))
    else $error("result not reduced");

endmodule

bind modular_exponentiation_prime_modulus modexp_checker u_modexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .power_result (power_result)
);

`default_nettype wire
